// ----- sv/efce_pkg.sv -----
// ----------------------------------------------------------------------------
// Escaped frame CRC encoder package
// Shared types, register codes and the CRC and stuffing functions of the
// byte-stuffing framer.
// ----------------------------------------------------------------------------
package efce_pkg;

    localparam int unsigned MAX_RESULTS = 12;
    localparam int unsigned BUF_W       = MAX_RESULTS * 8;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned ADDR_W      = 5;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;

    localparam logic [7:0]  SOF_RESET      = 8'd126;
    localparam logic [7:0]  EOF_RESET      = 8'd127;
    localparam logic [7:0]  ESC_RESET      = 8'd125;
    localparam logic [7:0]  CODE_SOF_RESET = 8'd1;
    localparam logic [7:0]  CODE_EOF_RESET = 8'd2;
    localparam logic [7:0]  CODE_ESC_RESET = 8'd3;

    typedef enum logic [2:0] {
        REG_SOF_BYTE     = 3'd0,
        REG_EOF_BYTE     = 3'd1,
        REG_ESC_BYTE     = 3'd2,
        REG_ESC_CODE_SOF = 3'd3,
        REG_ESC_CODE_EOF = 3'd4,
        REG_ESC_CODE_ESC = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0] sof_byte;
        logic [7:0] eof_byte;
        logic [7:0] esc_byte;
        logic [7:0] esc_code_sof;
        logic [7:0] esc_code_eof;
        logic [7:0] esc_code_esc;
    } cfg_t;

    // Up to two line bytes, the first in the low byte.
    typedef struct packed {
        logic [1:0]  len;
        logic [15:0] bytes;
    } stuff_t;

    function automatic logic [31:0] crc_feed(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Start marker is matched first, then end marker, then escape.
    function automatic stuff_t stuff_byte(logic [7:0] b, cfg_t cfg);
        stuff_t s;
        if (b == cfg.sof_byte) begin
            s.len   = 2'd2;
            s.bytes = {cfg.esc_code_sof, cfg.esc_byte};
        end else if (b == cfg.eof_byte) begin
            s.len   = 2'd2;
            s.bytes = {cfg.esc_code_eof, cfg.esc_byte};
        end else if (b == cfg.esc_byte) begin
            s.len   = 2'd2;
            s.bytes = {cfg.esc_code_esc, cfg.esc_byte};
        end else begin
            s.len   = 2'd1;
            s.bytes = {8'd0, b};
        end
        return s;
    endfunction

endpackage

// ----- sv/escaped_frame_crc_encoder.sv -----
// ----------------------------------------------------------------------------
// Escaped frame CRC encoder
// Frames a payload byte stream with start and end markers, byte-stuffs it and
// appends a stuffed CRC-32 before the end marker.
// ----------------------------------------------------------------------------
// Usage: payload bytes arrive as transfers on the s_ channel; s_tuser says
// whether s_tdata carries a byte and s_tlast closes the frame. A transfer with
// neither is dropped. The framed line stream leaves one byte per transfer on
// the m_ channel, with m_tlast on the final byte caused by each input transfer.
// Each input transfer is held in an input register and combinationally turned
// into its complete list of line bytes (start marker, stuffed data, stuffed
// CRC and end marker, up to twelve bytes) in a shift buffer.
// The first byte leaves from the shift buffer, loaded from the input register.
// Throughput: one line byte per cycle while the receiver takes it; an item
// produces one to three bytes for a data byte, the start marker included
// when it opens a frame, and up to twelve for a closing item. The shift
// buffer loads the next item as the last byte of the current one is taken.
// When the receiver stalls, the buffer holds and one further input transfer
// waits in the input register. Reset clears both, closes any open frame and
// loads the register defaults. Registers are written over the APB port.
// ----------------------------------------------------------------------------
module escaped_frame_crc_encoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tuser,   // [0] byte_present
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [efce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import efce_pkg::*;

    cfg_t                cfg_reg;
    reg_index_t          reg_sel;
    logic                cfg_write;

    logic                in_valid_reg;
    logic [7:0]          in_data_reg;
    logic                in_present_reg;
    logic                in_last_reg;

    logic                inside_frame_reg;
    logic                inside_frame_next;
    logic [31:0]         crc_reg;
    logic [31:0]         crc_next;

    logic [BUF_W-1:0]    buf_reg;
    logic [BUF_W-1:0]    buf_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    logic                idle_item;
    logic                buf_free;
    logic                load;
    logic                out_take;

    logic [31:0]         crc_base;
    logic [31:0]         crc_data;
    logic [31:0]         crc_final;
    stuff_t              st_data;
    stuff_t              st_crc [4];
    logic [BUF_W-1:0]    acc;
    logic [CNT_W-1:0]    acc_n;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sof_byte     <= SOF_RESET;
            cfg_reg.eof_byte     <= EOF_RESET;
            cfg_reg.esc_byte     <= ESC_RESET;
            cfg_reg.esc_code_sof <= CODE_SOF_RESET;
            cfg_reg.esc_code_eof <= CODE_EOF_RESET;
            cfg_reg.esc_code_esc <= CODE_ESC_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_SOF_BYTE:     cfg_reg.sof_byte     <= pwdata[7:0];
                REG_EOF_BYTE:     cfg_reg.eof_byte     <= pwdata[7:0];
                REG_ESC_BYTE:     cfg_reg.esc_byte     <= pwdata[7:0];
                REG_ESC_CODE_SOF: cfg_reg.esc_code_sof <= pwdata[7:0];
                REG_ESC_CODE_EOF: cfg_reg.esc_code_eof <= pwdata[7:0];
                REG_ESC_CODE_ESC: cfg_reg.esc_code_esc <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SOF_BYTE:     prdata = {24'd0, cfg_reg.sof_byte};
            REG_EOF_BYTE:     prdata = {24'd0, cfg_reg.eof_byte};
            REG_ESC_BYTE:     prdata = {24'd0, cfg_reg.esc_byte};
            REG_ESC_CODE_SOF: prdata = {24'd0, cfg_reg.esc_code_sof};
            REG_ESC_CODE_EOF: prdata = {24'd0, cfg_reg.esc_code_eof};
            REG_ESC_CODE_ESC: prdata = {24'd0, cfg_reg.esc_code_esc};
            default:          prdata = 32'd0;
        endcase
    end

    assign idle_item = !in_present_reg && !in_last_reg;
    assign out_take  = m_tvalid && m_tready;
    assign buf_free  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign load      = in_valid_reg && (idle_item || buf_free);
    assign s_tready  = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    always_comb begin
        crc_base  = inside_frame_reg ? crc_reg : crc_feed(CRC_PRESET, cfg_reg.sof_byte);
        crc_data  = in_present_reg ? crc_feed(crc_base, in_data_reg) : crc_base;
        crc_final = ~crc_feed(crc_data, cfg_reg.eof_byte);
        st_data   = stuff_byte(in_data_reg, cfg_reg);
        for (int i = 0; i < 4; i++) begin
            st_crc[i] = stuff_byte(crc_final[31 - 8*i -: 8], cfg_reg);
        end
    end

    always_comb begin
        acc   = '0;
        acc_n = '0;
        if (!inside_frame_reg) begin
            acc[7:0] = cfg_reg.sof_byte;
            acc_n    = CNT_W'(1);
        end
        if (in_present_reg) begin
            acc   = acc | ({{(BUF_W-16){1'b0}}, st_data.bytes} << {acc_n, 3'b000});
            acc_n = acc_n + {2'b00, st_data.len};
        end
        if (in_last_reg) begin
            for (int i = 0; i < 4; i++) begin
                acc   = acc | ({{(BUF_W-16){1'b0}}, st_crc[i].bytes} << {acc_n, 3'b000});
                acc_n = acc_n + {2'b00, st_crc[i].len};
            end
            acc   = acc | ({{(BUF_W-8){1'b0}}, cfg_reg.eof_byte} << {acc_n, 3'b000});
            acc_n = acc_n + CNT_W'(1);
        end
    end

    always_comb begin
        inside_frame_next = inside_frame_reg;
        crc_next          = crc_reg;
        buf_next          = buf_reg;
        cnt_next          = cnt_reg;
        if (load && !idle_item) begin
            buf_next = acc;
            cnt_next = acc_n;
            if (in_last_reg) begin
                inside_frame_next = 1'b0;
                crc_next          = CRC_PRESET;
            end else begin
                inside_frame_next = 1'b1;
                crc_next          = crc_data;
            end
        end else if (out_take) begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_frame_reg <= 1'b0;
            crc_reg          <= CRC_PRESET;
            cnt_reg          <= '0;
        end else begin
            inside_frame_reg <= inside_frame_next;
            crc_reg          <= crc_next;
            cnt_reg          <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = buf_reg[7:0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("Result count exceeds the buffer depth.");

    a_closed_preset: assert property (@(posedge aclk) disable iff (!aresetn)
        !inside_frame_reg |-> crc_reg == CRC_PRESET)
        else $error("CRC register not at preset outside a frame.");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !idle_item) |-> (cnt_reg == '0 || (cnt_reg == CNT_W'(1) && m_tready)))
        else $error("Result buffer overwritten before it drained.");

    a_sof_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !idle_item && !inside_frame_reg) |=> m_tdata == $past(cfg_reg.sof_byte))
        else $error("Frame did not open with the start marker.");

    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_last_reg) |=> !inside_frame_reg)
        else $error("Frame left open after its last item.");
`endif

endmodule
